// ===== design/rcm_pkg.sv =====
// Shared constants, controller commands and status for the character modular exponentiation core
`timescale 1ns / 1ps
package rcm_pkg;
  localparam int unsigned LETTER_A = 97;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef struct packed {
    logic load;      // latch item, start base reduction
    logic mul_start; // start one modular multiply
    logic sel_sq;    // multiply is a square (else acc*base)
    logic acc_write; // store multiply result in acc
    logic base_write;// store reduced base
    logic exp_shift; // advance exponent bit
    logic finish;    // fill the output register
  } rcm_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_bit;
    logic exp_zero;
    logic mod_small;
    logic out_busy;
  } rcm_stat_t;
endpackage

// ===== design/rsa_char_modexp_core.sv =====
// Top level of the character modular exponentiation core
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | tdata: func, plain_char, cipher_in
//  m_axis  | out | tvalid/tready    | tdata: cipher_out, char_out
//  cfg     | in  | cfg_we           | cfg_index, cfg_data
// One word takes a base reduction, 31 square rounds and up to 31 multiply rounds,
// each a 32-step bit-serial modular multiply.
// Reset is synchronous; registers return to modulus 2^31-1, exponents 3.
// The next word waits while the result sits unread in the output register.
`timescale 1ns / 1ps
module rsa_char_modexp_core #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // func, plain_char[7:1], cipher_in[38:8], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // cipher_out[30:0], char_out[38:31], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import rcm_pkg::*;
  rcm_cmd_t  cmd;
  rcm_stat_t stat;
  logic [30:0] cipher_out;
  logic [7:0]  char_out;

  rcm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  rcm_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_en(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_func(s_axis_tdata[0]), .in_char(s_axis_tdata[7:1]),
    .in_cipher(s_axis_tdata[38:8]), .cmd(cmd), .stat(stat),
    .out_take(m_axis_tvalid && m_axis_tready), .out_valid(m_axis_tvalid),
    .out_cipher(cipher_out), .out_char(char_out)
  );

  assign m_axis_tdata = {1'b0, char_out, cipher_out};

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.mul_start)) else $error("load and multiply together");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.out_busy) else $error("output overwritten");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("double accept");
endmodule

// ===== design/rcm_datapath.sv =====
// Datapath: operand registers, bit-serial modular multiplier and output register
`timescale 1ns / 1ps
module rcm_datapath #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_en,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                in_func,
  input  logic [6:0]          in_char,
  input  logic [30:0]         in_cipher,
  input  rcm_pkg::rcm_cmd_t   cmd,
  output rcm_pkg::rcm_stat_t  stat,
  input  logic                out_take,
  output logic                out_valid,
  output logic [30:0]         out_cipher,
  output logic [7:0]          out_char
);
  import rcm_pkg::*;
  localparam int unsigned W = MOD_BITS;

  logic [W-1:0] modulus;
  logic [30:0]  pub_exp, priv_exp;
  logic         func;
  logic [30:0]  exp_sh;
  logic         exp_none;
  logic [W-1:0] acc, base;
  logic [W:0]   mul_r;
  logic [W-1:0] mul_b;
  logic [31:0]  mul_a;
  logic [4:0]   mul_cnt;
  logic         mul_busy, mul_done;
  logic         neg_base;
  logic [W+1:0] dbl, dbl_sub, add_v, add_sub;
  logic [W:0]   r_dbl, r_add;

  // one shift-and-add step: double, add b on the top bit of a, reduce each time
  always_comb begin
    dbl = {mul_r, 1'b0};
    dbl_sub = dbl - {2'b00, modulus};
    r_dbl = dbl_sub[W+1] ? dbl[W:0] : dbl_sub[W:0];
    add_v = {1'b0, r_dbl} + (mul_a[31] ? {2'b00, mul_b} : '0);
    add_sub = add_v - {2'b00, modulus};
    r_add = add_sub[W+1] ? add_v[W:0] : add_sub[W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(31'h7FFFFFFF);
      pub_exp <= 31'd3;
      priv_exp <= 31'd3;
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_MODULUS:  modulus <= cfg_data[W-1:0];
          REG_PUB_EXP:  pub_exp <= cfg_data;
          REG_PRIV_EXP: priv_exp <= cfg_data;
          default: ;
        endcase
      end
      mul_done <= 1'b0;
      if (cmd.load || cmd.mul_start) begin
        mul_busy <= 1'b1;
        mul_cnt <= '0;
        mul_r <= '0;
      end else if (mul_busy) begin
        mul_r <= r_add;
        mul_a <= {mul_a[30:0], 1'b0};
        if (mul_cnt == 5'd31) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
        mul_cnt <= mul_cnt + 1'b1;
      end
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
    if (cmd.load) begin
      func <= in_func;
      exp_sh <= (in_func == FUNC_DECRYPT) ? priv_exp : pub_exp;
      exp_none <= (((in_func == FUNC_DECRYPT) ? priv_exp : pub_exp) == 31'd0);
      neg_base <= (in_func == FUNC_ENCRYPT) && (in_char < 7'(LETTER_A));
      // base reduced as base*1; a letter below 'a' reduces its distance
      mul_b <= W'(1);
      if (in_func == FUNC_DECRYPT) mul_a <= {1'b0, in_cipher};
      else if (in_char >= 7'(LETTER_A)) mul_a <= 32'(in_char - 7'(LETTER_A));
      else mul_a <= 32'(7'(LETTER_A) - in_char);
    end
    if (cmd.mul_start) begin
      mul_a <= 32'(acc);
      mul_b <= cmd.sel_sq ? acc : base;
    end
    if (cmd.base_write)
      base <= (neg_base && mul_r[W-1:0] != '0) ? modulus - mul_r[W-1:0] : mul_r[W-1:0];
    if (cmd.load) acc <= W'(1);
    else if (cmd.acc_write) acc <= mul_r[W-1:0];
    if (cmd.exp_shift) exp_sh <= {exp_sh[29:0], 1'b0};
    if (cmd.finish) begin
      logic [30:0] p;
      p = stat.exp_zero ? 31'd1 : (stat.mod_small ? 31'd0 : 31'(acc));
      out_cipher <= (func == FUNC_ENCRYPT) ? p : '0;
      out_char <= (func == FUNC_DECRYPT) ? 8'(p[7:0] + 8'(LETTER_A)) : '0;
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.exp_bit = exp_sh[30];
  assign stat.exp_zero = exp_none;
  assign stat.mod_small = (modulus < W'(2));
  assign stat.out_busy = out_valid && !out_take;
endmodule

// ===== design/rcm_ctrl.sv =====
// Controller: sequences base reduction and square-and-multiply rounds
`timescale 1ns / 1ps
module rcm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcm_pkg::rcm_stat_t stat,
  output rcm_pkg::rcm_cmd_t  cmd
);
  import rcm_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_BASE = 3'd1, S_SQ = 3'd2, S_SQW = 3'd3,
                         S_MULW = 3'd4, S_DONE = 3'd5;
  logic [2:0] state, state_next;
  logic [4:0] round, round_next;
  logic       zero_e, zero_e_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    round_next = round;
    zero_e_next = zero_e;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: if (stat.mul_done) begin
        cmd.base_write = 1'b1;
        zero_e_next = 1'b0;
        round_next = 5'd0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.sel_sq = 1'b1;
        state_next = S_SQW;
      end
      S_SQW: if (stat.mul_done) begin
        cmd.acc_write = 1'b1;
        if (stat.exp_bit) state_next = S_MULW;
        else begin
          cmd.exp_shift = 1'b1;
          round_next = round + 1'b1;
          state_next = (round == 5'd30) ? S_DONE : S_SQ;
        end
      end
      S_MULW: begin
        if (!stat.mul_done && !zero_e) begin
          cmd.mul_start = 1'b1;
          zero_e_next = 1'b1;
        end else if (stat.mul_done) begin
          cmd.acc_write = 1'b1;
          cmd.exp_shift = 1'b1;
          zero_e_next = 1'b0;
          round_next = round + 1'b1;
          state_next = (round == 5'd30) ? S_DONE : S_SQ;
        end
      end
      S_DONE: if (!stat.out_busy) begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      zero_e <= 1'b0;
    end else begin
      state <= state_next;
      round <= round_next;
      zero_e <= zero_e_next;
    end
  end
endmodule
